// ===== sv/iskl_pkg.sv =====
// Package: shared types, constants and helpers for the info string key lookup.
package iskl_pkg;

  localparam int KEY_MAX = 32;
  localparam int KEY_IDX_W = $clog2(KEY_MAX + 1);
  localparam int KEY_SEL_W = $clog2(KEY_MAX);
  localparam int CHARS_W = 256;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NUL = 8'h00;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_CHARS_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_CHARS_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_CHARS_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_CHARS_D = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE_LENGTH = 3'd5;

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] ch_fold;
    logic       is_nul;
    logic       is_bslash;
  } item_t;

  typedef struct packed {
    logic [4:0]         key_length;
    logic [CHARS_W-1:0] key_chars;
    logic [7:0]         max_value_length;
  } cfg_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) r = c + 8'h20;
    return r;
  endfunction

endpackage

// ===== sv/info_string_key_lookup.sv =====
// Top level: configuration registers, front stage, request queue and back stage.
// Path: an accepted character is registered in the front stage, then in the queue, then in the result register.
// Throughput: one character per cycle while in_stall is low; the back stage state machine retires one
//   queued character per cycle whenever its output register can be loaded.
// Reset: synchronous active-low rst_n clears the queue, phase and counters; the
//   key registers clear to zero and max_value_length to 255.
module info_string_key_lookup (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [iskl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [iskl_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_ch,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_value_char,
  output logic                               out_has_char,
  output logic                               out_found,
  output logic                               out_last
);
  import iskl_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  logic  push, pop, fifo_full, head_valid;
  item_t push_item, head_item;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_KEY_LENGTH:       cfg_nxt.key_length = cfg_wdata[4:0];
        REG_KEY_CHARS_A:      cfg_nxt.key_chars[63:0] = cfg_wdata;
        REG_KEY_CHARS_B:      cfg_nxt.key_chars[127:64] = cfg_wdata;
        REG_KEY_CHARS_C:      cfg_nxt.key_chars[191:128] = cfg_wdata;
        REG_KEY_CHARS_D:      cfg_nxt.key_chars[255:192] = cfg_wdata;
        REG_MAX_VALUE_LENGTH: cfg_nxt.max_value_length = cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_length       <= '0;
      cfg_r.key_chars        <= '0;
      cfg_r.max_value_length <= 8'hFF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  iskl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_ch     (in_ch),
    .push      (push),
    .push_item (push_item),
    .fifo_full (fifo_full)
  );

  iskl_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  iskl_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .head_valid     (head_valid),
    .head_item      (head_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value_char (out_value_char),
    .out_has_char   (out_has_char),
    .out_found      (out_found),
    .out_last       (out_last)
  );

endmodule

// ===== sv/iskl_front.sv =====
// Front stage: accepts characters and classifies them into queue items.
module iskl_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_ch,
  output logic               push,
  output iskl_pkg::item_t    push_item,
  input  logic               fifo_full
);
  import iskl_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic  accept;

  assign in_stall  = valid_r && fifo_full;
  assign accept    = in_valid && !in_stall;
  assign push      = valid_r && !fifo_full;
  assign push_item = item_r;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (accept) begin
      valid_nxt          = 1'b1;
      item_nxt.ch        = in_ch;
      item_nxt.ch_fold   = fold(in_ch);
      item_nxt.is_nul    = (in_ch == CH_NUL);
      item_nxt.is_bslash = (in_ch == CH_BSLASH);
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

// ===== sv/iskl_fifo.sv =====
// Short queue between the front and back stages.
module iskl_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  iskl_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output iskl_pkg::item_t head_item
);
  import iskl_pkg::*;

  item_t                 mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = wr_ptr_r + 1'b1;
    if (pop) rd_ptr_nxt = rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (!push && pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) mem[wr_ptr_r] <= push_item;
  end

endmodule

// ===== sv/iskl_back.sv =====
// Back stage: key match state machine and the registered result output.
module iskl_back (
  input  logic            clk,
  input  logic            rst_n,
  input  iskl_pkg::cfg_t  cfg,
  input  logic            head_valid,
  input  iskl_pkg::item_t head_item,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_value_char,
  output logic            out_has_char,
  output logic            out_found,
  output logic            out_last
);
  import iskl_pkg::*;

  typedef enum logic [2:0] {
    PH_START,
    PH_KEY,
    PH_VALUE,
    PH_SKIP,
    PH_DONE
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [KEY_IDX_W-1:0] key_index_r, key_index_nxt;
  logic                 key_mismatch_r, key_mismatch_nxt;
  logic [7:0]           value_count_r, value_count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           value_char_r, value_char_nxt;
  logic                 has_char_r, has_char_nxt;
  logic                 found_r, found_nxt;
  logic                 last_r, last_nxt;

  logic                 emit;
  logic [7:0]           key_ch;
  logic                 ch_miss;

  assign pop = head_valid && (!out_valid_r || !out_stall);
  assign key_ch = cfg.key_chars[{key_index_r[KEY_SEL_W-1:0], 3'b000} +: 8];
  assign ch_miss = (key_index_r >= KEY_IDX_W'(KEY_MAX))
                || (key_index_r >= {1'b0, cfg.key_length})
                || (head_item.ch_fold != fold(key_ch));

  always_comb begin
    phase_nxt        = phase_r;
    key_index_nxt    = key_index_r;
    key_mismatch_nxt = key_mismatch_r;
    value_count_nxt  = value_count_r;
    emit             = 1'b0;
    value_char_nxt   = 8'h00;
    has_char_nxt     = 1'b0;
    found_nxt        = 1'b0;
    last_nxt         = 1'b0;
    if (pop) begin
      if (head_item.is_nul) begin
        phase_nxt        = PH_START;
        key_index_nxt    = '0;
        key_mismatch_nxt = 1'b0;
        value_count_nxt  = '0;
        emit             = (phase_r != PH_DONE);
        found_nxt        = (phase_r == PH_VALUE);
        last_nxt         = 1'b1;
      end else begin
        case (phase_r)
          PH_START: begin
            phase_nxt        = PH_KEY;
            key_index_nxt    = '0;
            key_mismatch_nxt = 1'b0;
          end
          PH_KEY: begin
            if (head_item.is_bslash) begin
              if (!key_mismatch_r && key_index_r == {1'b0, cfg.key_length}) begin
                phase_nxt       = PH_VALUE;
                value_count_nxt = '0;
              end else begin
                phase_nxt = PH_SKIP;
              end
            end else begin
              if (ch_miss) key_mismatch_nxt = 1'b1;
              if (key_index_r < KEY_IDX_W'(KEY_MAX)) key_index_nxt = key_index_r + 1'b1;
            end
          end
          PH_VALUE: begin
            if (head_item.is_bslash) begin
              phase_nxt = PH_DONE;
              emit      = 1'b1;
              found_nxt = 1'b1;
              last_nxt  = 1'b1;
            end else if (value_count_r < cfg.max_value_length) begin
              value_count_nxt = value_count_r + 1'b1;
              emit            = 1'b1;
              value_char_nxt  = head_item.ch;
              has_char_nxt    = 1'b1;
            end
          end
          PH_SKIP: begin
            if (head_item.is_bslash) begin
              phase_nxt        = PH_KEY;
              key_index_nxt    = '0;
              key_mismatch_nxt = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end
    if (pop) out_valid_nxt = emit;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_START;
      key_index_r    <= '0;
      key_mismatch_r <= 1'b0;
      value_count_r  <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      key_index_r    <= key_index_nxt;
      key_mismatch_r <= key_mismatch_nxt;
      value_count_r  <= value_count_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    if (pop && emit) begin
      value_char_r <= value_char_nxt;
      has_char_r   <= has_char_nxt;
      found_r      <= found_nxt;
      last_r       <= last_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value_char = value_char_r;
  assign out_has_char   = has_char_r;
  assign out_found      = found_r;
  assign out_last       = last_r;

endmodule

// ===== sim/iskl_lookup_checker.sv =====
`timescale 1ns / 100ps
// Checker: predicts the key lookup results from observed requests and compares the DUT output.
module iskl_lookup_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [iskl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [iskl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [7:0]                      in_ch,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [7:0]                      out_value_char,
  input  logic                            out_has_char,
  input  logic                            out_found,
  input  logic                            out_last,
  output int                              fail_count,
  output int                              pending_results
);
  import iskl_pkg::*;

  typedef enum logic [2:0] {
    SCAN_START,
    SCAN_KEY,
    SCAN_VALUE,
    SCAN_SKIP,
    SCAN_DONE
  } scan_phase_t;

  typedef struct packed {
    logic [7:0] value_char;
    logic       has_char;
    logic       found;
    logic       last;
  } lookup_result_t;

  logic [4:0]         want_len;
  logic [CHARS_W-1:0] want_key;
  logic [7:0]         value_limit;

  scan_phase_t scan_phase;
  int          key_pos;
  logic        key_differs;
  int          value_sent;

  lookup_result_t expected_q[$];

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  task automatic push_result(input logic [7:0] c, input logic has, input logic fnd,
                             input logic lst);
    lookup_result_t r;
    r.value_char = c;
    r.has_char = has;
    r.found = fnd;
    r.last = lst;
    expected_q.push_back(r);
  endtask

  task automatic open_key();
    scan_phase = SCAN_KEY;
    key_pos = 0;
    key_differs = 1'b0;
  endtask

  task automatic predict_char(input logic [7:0] c);
    if (c == CH_NUL) begin
      if (scan_phase == SCAN_VALUE) push_result(8'h00, 1'b0, 1'b1, 1'b1);
      else if (scan_phase != SCAN_DONE) push_result(8'h00, 1'b0, 1'b0, 1'b1);
      scan_phase = SCAN_START;
      key_pos = 0;
      key_differs = 1'b0;
      value_sent = 0;
    end else begin
      case (scan_phase)
        SCAN_START: open_key();
        SCAN_KEY: begin
          if (c == CH_BSLASH) begin
            if (!key_differs && key_pos == int'(want_len)) begin
              scan_phase = SCAN_VALUE;
              value_sent = 0;
            end else begin
              scan_phase = SCAN_SKIP;
            end
          end else begin
            if (key_pos >= KEY_MAX || key_pos >= int'(want_len) ||
                lower_ascii(c) != lower_ascii(want_key[8*key_pos +: 8]))
              key_differs = 1'b1;
            if (key_pos < KEY_MAX) key_pos++;
          end
        end
        SCAN_VALUE: begin
          if (c == CH_BSLASH) begin
            scan_phase = SCAN_DONE;
            push_result(8'h00, 1'b0, 1'b1, 1'b1);
          end else if (value_sent < int'(value_limit)) begin
            value_sent++;
            push_result(c, 1'b1, 1'b0, 1'b0);
          end
        end
        SCAN_SKIP: if (c == CH_BSLASH) open_key();
        default: ;
      endcase
    end
  endtask

  always @(posedge clk) begin
    lookup_result_t got;
    lookup_result_t want;
    if (!rst_n) begin
      want_len = '0;
      want_key = '0;
      value_limit = 8'd255;
      scan_phase = SCAN_START;
      key_pos = 0;
      key_differs = 1'b0;
      value_sent = 0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_LENGTH:       want_len = cfg_wdata[4:0];
          REG_KEY_CHARS_A:      want_key[63:0] = cfg_wdata;
          REG_KEY_CHARS_B:      want_key[127:64] = cfg_wdata;
          REG_KEY_CHARS_C:      want_key[191:128] = cfg_wdata;
          REG_KEY_CHARS_D:      want_key[255:192] = cfg_wdata;
          REG_MAX_VALUE_LENGTH: value_limit = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {out_value_char, out_has_char, out_found, out_last};
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, %s%02h has=%0b found=%0b last=%0b",
                   $time, "got char=", got.value_char, got.has_char, got.found,
                   got.last);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: result differs, expected char=%02h has=%0b found=%0b last=%0b,",
                     $time, want.value_char, want.has_char, want.found, want.last);
            $display("  got char=%02h has=%0b found=%0b last=%0b",
                     got.value_char, got.has_char, got.found, got.last);
          end
        end
      end
      if (in_valid && !in_stall) predict_char(in_ch);
    end
    pending_results = expected_q.size();
  end

endmodule

// ===== sim/tb_info_string_key_lookup.sv =====
`timescale 1ns / 100ps
// Testbench top: feeds info strings and key settings to the lookup and reports the verdict.
module tb_info_string_key_lookup;
  import iskl_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam int RANDOM_CHARS = 1600;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [8*23-1:0] DIRECTED_KEYED = {
    8'h00,
    8'h5C, 8'h61, 8'h42, 8'h5C, 8'hFF, 8'h01, 8'h5C, 8'h7A, 8'h00,
    8'h5C, 8'h61, 8'h00,
    8'h41, 8'h71, 8'h5C, 8'h72, 8'h5C, 8'h41, 8'h62, 8'h5C, 8'h73, 8'h00
  };
  localparam logic [8*4-1:0] DIRECTED_EMPTY = {8'h5C, 8'h5C, 8'h41, 8'h00};

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;
  typedef enum int {
    KEY_EXACT,
    KEY_SHORT,
    KEY_EXTRA,
    KEY_ALTERED,
    KEY_OTHER,
    KEY_OVERSIZE
  } key_form_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_ch = 8'h00;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_value_char;
  logic                  out_has_char;
  logic                  out_found;
  logic                  out_last;
  int                    fail_count;
  int                    pending_results;

  logic [7:0]         char_fifo[$];
  int                 burst_left = 0;
  int                 gap_left = 0;
  int                 hold_asked = 0;
  int                 hold_served = 0;
  int                 hold_left = 0;
  int                 mode_left = 0;
  rx_mode_t           rx_mode = RX_FREE;
  logic [4:0]         key_len_now = '0;
  logic [CHARS_W-1:0] key_now = '0;
  int                 random_chars = 0;

  info_string_key_lookup dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_ch(in_ch),
    .out_valid(out_valid), .out_stall(out_stall), .out_value_char(out_value_char),
    .out_has_char(out_has_char), .out_found(out_found), .out_last(out_last)
  );

  iskl_lookup_checker lookup_check (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_ch(in_ch),
    .out_valid(out_valid), .out_stall(out_stall), .out_value_char(out_value_char),
    .out_has_char(out_has_char), .out_found(out_found), .out_last(out_last),
    .fail_count(fail_count), .pending_results(pending_results)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // sender: bursts with random gaps; a stalled request is held unchanged
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) void'(char_fifo.pop_front());
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 32);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (char_fifo.size() > 0) begin
        burst_left--;
        in_valid <= 1'b1;
        in_ch <= char_fifo[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_asked != hold_served) begin
      hold_served++;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(30, 200);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= ~out_stall;
      endcase
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_key(input logic [4:0] len, input logic [CHARS_W-1:0] k,
                          input logic [7:0] limit);
    logic [CFG_DATA_W-1:0] data;
    key_len_now = len;
    key_now = k;
    data = {$urandom, $urandom};
    data[4:0] = len;
    write_reg(REG_KEY_LENGTH, data);
    write_reg(REG_KEY_CHARS_A, k[63:0]);
    write_reg(REG_KEY_CHARS_B, k[127:64]);
    write_reg(REG_KEY_CHARS_C, k[191:128]);
    write_reg(REG_KEY_CHARS_D, k[255:192]);
    data = {$urandom, $urandom};
    data[7:0] = limit;
    write_reg(REG_MAX_VALUE_LENGTH, data);
    if ($urandom_range(0, 1) == 1) write_reg(REG_SPARE_6, {$urandom, $urandom});
    if ($urandom_range(0, 1) == 1) write_reg(REG_SPARE_7, {$urandom, $urandom});
  endtask

  task automatic drain();
    while (char_fifo.size() != 0 || pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic push_char(input logic [7:0] c);
    char_fifo.push_back(c);
    random_chars++;
  endtask

  // any byte but NUL and backslash, letters favored
  function automatic logic [7:0] text_char();
    logic [7:0] c;
    c = CH_BSLASH;
    while (c == CH_BSLASH || c == CH_NUL) begin
      case ($urandom_range(0, 3))
        0:       c = 8'h61 + 8'($urandom_range(0, 25));
        1:       c = 8'h41 + 8'($urandom_range(0, 25));
        default: c = 8'($urandom_range(1, 255));
      endcase
    end
    return c;
  endfunction

  function automatic logic [CHARS_W-1:0] make_key(input int len);
    logic [CHARS_W-1:0] k;
    for (int j = 0; j < CHARS_W / 32; j++) k[32*j +: 32] = $urandom;
    for (int i = 0; i < len; i++) k[8*i +: 8] = text_char();
    return k;
  endfunction

  task automatic push_key(input key_form_t form);
    int n;
    int bad;
    logic [7:0] c;
    n = int'(key_len_now);
    case (form)
      KEY_SHORT:    n = (n > 0) ? n - 1 : 0;
      KEY_EXTRA:    n = n + 1;
      KEY_OTHER:    n = $urandom_range(0, 8);
      KEY_OVERSIZE: n = $urandom_range(KEY_MAX + 1, KEY_MAX + 8);
      default: ;
    endcase
    bad = (form == KEY_ALTERED && n > 0) ? $urandom_range(0, n - 1) : -1;
    for (int i = 0; i < n; i++) begin
      if (form == KEY_OTHER || i >= int'(key_len_now) || i == bad) begin
        c = text_char();
      end else begin
        c = key_now[8*i +: 8];
        if (c == CH_NUL || c == CH_BSLASH) begin
          c = text_char();
        end else if ($urandom_range(0, 1) == 1) begin
          if (c >= 8'h41 && c <= 8'h5A) c = c + 8'h20;
          else if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
        end
      end
      push_char(c);
    end
  endtask

  task automatic push_info_string();
    int pairs;
    int hit;
    int vlen;
    pairs = $urandom_range(1, 4);
    hit = ($urandom_range(0, 3) == 0) ? -1 : $urandom_range(0, pairs - 1);
    push_char(($urandom_range(0, 15) == 0) ? text_char() : CH_BSLASH);
    for (int p = 0; p < pairs; p++) begin
      if (p > 0) push_char(CH_BSLASH);
      push_key((p == hit) ? KEY_EXACT : key_form_t'($urandom_range(1, 5)));
      push_char(CH_BSLASH);
      vlen = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
      repeat (vlen) push_char(text_char());
    end
    if ($urandom_range(0, 2) == 0) begin
      push_char(CH_BSLASH);
      repeat ($urandom_range(0, 3)) push_char(text_char());
    end
    push_char(CH_NUL);
  endtask

  task automatic push_broken_string();
    case ($urandom_range(0, 3))
      0: begin
        repeat ($urandom_range(1, 16)) begin
          case ($urandom_range(0, 5))
            0:       push_char(CH_NUL);
            1:       push_char(CH_BSLASH);
            default: push_char(8'($urandom_range(0, 255)));
          endcase
        end
      end
      1: ;
      2: begin
        push_char(CH_BSLASH);
        push_key(KEY_EXACT);
      end
      default: begin
        push_char(CH_BSLASH);
        push_key(KEY_OTHER);
        push_char(CH_BSLASH);
        repeat ($urandom_range(0, 6)) push_char(text_char());
      end
    endcase
    push_char(CH_NUL);
  endtask

  initial begin
    int phase_no;
    int len;
    int pos;
    logic [CHARS_W-1:0] k;
    logic [7:0] limit;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    load_key(5'd2, {240'h0, 16'h6241}, 8'd255);
    @(negedge clk);
    for (int i = 22; i >= 0; i--) push_char(DIRECTED_KEYED[8*i +: 8]);
    drain();
    load_key(5'd0, '0, 8'd0);
    @(negedge clk);
    for (int i = 3; i >= 0; i--) push_char(DIRECTED_EMPTY[8*i +: 8]);
    drain();

    random_chars = 0;
    phase_no = 0;
    while (random_chars < RANDOM_CHARS) begin
      case (phase_no)
        0: begin
          len = 31;
          limit = 8'd255;
          k = make_key(31);
        end
        1: begin
          len = 0;
          limit = 8'd0;
          k = make_key(0);
        end
        2: begin
          len = $urandom_range(1, 8);
          limit = 8'd1;
          k = '1;
        end
        3: begin
          len = $urandom_range(2, 6);
          limit = 8'($urandom_range(2, 8));
          k = make_key(len);
          pos = $urandom_range(0, len - 1);
          k[8*pos +: 8] = CH_NUL;
        end
        default: begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
          limit = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3))
                                              : 8'($urandom_range(4, 255));
          k = make_key(len);
        end
      endcase
      load_key(5'(len), k, limit);
      @(negedge clk);
      if (phase_no == 0) begin
        // value longer than the limit and the count range
        push_char(CH_BSLASH);
        push_key(KEY_EXACT);
        push_char(CH_BSLASH);
        repeat (270) push_char(text_char());
        push_char(CH_NUL);
      end
      repeat ($urandom_range(4, 10)) begin
        if ($urandom_range(0, 3) == 0) push_broken_string();
        else push_info_string();
      end
      if (phase_no == 2) hold_asked++;
      drain();
      phase_no++;
    end

    if (fail_count == 0 && pending_results == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
